[hw/rtl/rkst_pkg.sv]
// Shared types, codes and the sequencer microprogram of the range k-th smallest block.
`timescale 1ns / 1ps
`default_nettype none

package rkst_pkg;

    localparam int MAX_ELEMENTS_DEF = 1024;
    localparam int VALUE_BITS_DEF   = 16;
    localparam int NODE_POOL_DEF    = 32768;

    localparam int VALUE_W = 16;
    localparam int INDEX_W = 11;

    typedef enum logic [1:0] {
        ST_QUERY   = 2'd0,
        ST_APPEND  = 2'd1,
        ST_INVALID = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef struct packed {
        logic                operation;
        logic [VALUE_W-1:0]  value;
        logic [INDEX_W-1:0]  left_index;
        logic [INDEX_W-1:0]  right_index;
        logic [INDEX_W-1:0]  rank;
    } t_in_item;

    typedef struct packed {
        logic [VALUE_W-1:0]  kth_value;
        t_status             status;
    } t_out_item;

    // microprogram addresses
    typedef logic [3:0] t_step;

    localparam t_step STEP_IDLE      = 4'd0;
    localparam t_step STEP_A_CHECK   = 4'd1;
    localparam t_step STEP_A_ROOT    = 4'd2;
    localparam t_step STEP_A_LEVEL   = 4'd3;
    localparam t_step STEP_A_LEAF    = 4'd4;
    localparam t_step STEP_Q_CHECK   = 4'd5;
    localparam t_step STEP_Q_ROOT    = 4'd6;
    localparam t_step STEP_Q_LEVEL   = 4'd7;
    localparam t_step STEP_OUT_QUERY = 4'd8;
    localparam t_step STEP_OUT_FULL  = 4'd9;
    localparam t_step STEP_OUT_APP   = 4'd10;
    localparam t_step STEP_OUT_INV   = 4'd11;

    // datapath action of a step
    typedef enum logic [3:0] {
        DP_NONE,
        DP_APP_CHECK,
        DP_APP_ROOT,
        DP_APP_LEVEL,
        DP_APP_LEAF,
        DP_Q_CHECK,
        DP_Q_ROOT,
        DP_Q_LEVEL,
        DP_OUT
    } t_dp;

    // sequencing of a step
    typedef enum logic [2:0] {
        JC_NEXT,
        JC_GOTO,
        JC_DISPATCH,
        JC_IF_FULL,
        JC_IF_INVALID,
        JC_LOOP,
        JC_OUT
    } t_jc;

    typedef struct packed {
        t_dp      dp;
        t_jc      jc;
        t_step    tgt;
        t_step    alt;
        t_status  st;
    } t_uword;

    function automatic t_uword uc_rom(input t_step s);
        t_uword w;
        w = '{dp: DP_NONE, jc: JC_GOTO, tgt: STEP_IDLE, alt: STEP_IDLE, st: ST_QUERY};
        case (s)
            STEP_IDLE: begin
                w.jc  = JC_DISPATCH;
                w.tgt = STEP_A_CHECK;
                w.alt = STEP_Q_CHECK;
            end
            STEP_A_CHECK: begin
                w.dp  = DP_APP_CHECK;
                w.jc  = JC_IF_FULL;
                w.tgt = STEP_OUT_FULL;
            end
            STEP_A_ROOT: begin
                w.dp = DP_APP_ROOT;
                w.jc = JC_NEXT;
            end
            STEP_A_LEVEL: begin
                w.dp  = DP_APP_LEVEL;
                w.jc  = JC_LOOP;
                w.tgt = STEP_A_LEVEL;
            end
            STEP_A_LEAF: begin
                w.dp  = DP_APP_LEAF;
                w.jc  = JC_GOTO;
                w.tgt = STEP_OUT_APP;
            end
            STEP_Q_CHECK: begin
                w.dp  = DP_Q_CHECK;
                w.jc  = JC_IF_INVALID;
                w.tgt = STEP_OUT_INV;
            end
            STEP_Q_ROOT: begin
                w.dp = DP_Q_ROOT;
                w.jc = JC_NEXT;
            end
            STEP_Q_LEVEL: begin
                w.dp  = DP_Q_LEVEL;
                w.jc  = JC_LOOP;
                w.tgt = STEP_Q_LEVEL;
            end
            STEP_OUT_QUERY: begin
                w.dp = DP_OUT;
                w.jc = JC_OUT;
                w.st = ST_QUERY;
            end
            STEP_OUT_FULL: begin
                w.dp = DP_OUT;
                w.jc = JC_OUT;
                w.st = ST_FULL;
            end
            STEP_OUT_APP: begin
                w.dp = DP_OUT;
                w.jc = JC_OUT;
                w.st = ST_APPEND;
            end
            STEP_OUT_INV: begin
                w.dp = DP_OUT;
                w.jc = JC_OUT;
                w.st = ST_INVALID;
            end
            default: begin
                w.jc  = JC_GOTO;
                w.tgt = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/rkst_ram.sv]
// Generic RAM: one write port, two registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module rkst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic      [WIDTH-1:0]         o_rdata_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

`default_nettype wire

[hw/rtl/range_kth_smallest_persistent_tree.sv]
// Range k-th smallest over an append-only sequence, persistent counting trie, microcoded.
//
// Input channel (i_in_valid / o_in_ready / i_in_data) takes one word per item: an
// append (operation 0) stores value as the next element and creates a new version;
// a query (operation 1) returns the rank-th smallest value of elements
// left_index..right_index. Output channel (o_out_valid / i_out_ready / o_out_data)
// gives exactly one word per item with a status code.
// An append steps through its check, root, one step per trie level and leaf steps before
// its result is loaded into the output register, a query through its check, root and
// level steps: one trie level per cycle, set by the node memory's registered read that
// each level's address depends on. A full store or an invalid query goes from its check
// step straight to its output step. Items are processed one at a time; the sequencer is
// idle from the load onward, so the next word can be taken as soon as the result is
// loaded, even while the previous result waits.
// If the receiver stalls with a result still held, the sequencer parks on its
// output step until the register frees up.
// Reset empties the store (no elements, first free node 1); no clearing pass is
// needed as node 0 and version 0 read as the shared empty node.
`timescale 1ns / 1ps
`default_nettype none

module range_kth_smallest_persistent_tree #(
    parameter int MAX_ELEMENTS = rkst_pkg::MAX_ELEMENTS_DEF,
    parameter int VALUE_BITS   = rkst_pkg::VALUE_BITS_DEF,
    parameter int NODE_POOL    = rkst_pkg::NODE_POOL_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire rkst_pkg::t_in_item i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output rkst_pkg::t_out_item     o_out_data
);

    import rkst_pkg::*;

    localparam int CW = $clog2(MAX_ELEMENTS + 1);   // element count and version index
    localparam int PW = $clog2(NODE_POOL);          // node index
    localparam int FW = PW + 1;                     // free pointer may reach NODE_POOL
    localparam int LW = $clog2(VALUE_BITS + 1);
    localparam int KW = (CW > INDEX_W) ? CW : INDEX_W;
    localparam int VD = MAX_ELEMENTS + 1;

    // each node keeps the element count of its left subtree
    typedef struct packed {
        logic [CW-1:0] lc;
        logic [PW-1:0] left;
        logic [PW-1:0] right;
    } t_node;

    t_step             r_step, n_step;
    t_uword            uw;
    logic [CW-1:0]     r_total, n_total;
    logic [FW-1:0]     r_next_free, n_next_free;
    t_in_item          r_item;
    logic [VALUE_BITS-1:0] r_res, n_res;
    logic [VALUE_BITS-1:0] val, val_sh;
    logic [KW-1:0]     r_k, n_k;
    logic [LW-1:0]     r_lvl, n_lvl;
    logic [LW-1:0]     sh;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out, n_out;

    logic              in_accept, out_free, full, invalid;
    logic              app_bit, take_right;
    logic [CW-1:0]     diff;
    logic [KW-1:0]     x, range_len;

    // node memory
    logic              nd_we;
    logic [PW-1:0]     nd_wa, nd_ra, nd_rb;
    t_node             nd_wd, nd_raw_a, nd_raw_b, nd_a, nd_b;
    logic              r_nd_za, r_nd_zb;

    // version root memory
    logic              vr_we;
    logic [CW-1:0]     vr_wa, vr_ra, vr_rb;
    logic [PW-1:0]     vr_wd, vr_raw_a, vr_raw_b, vr_a, vr_b;
    logic              r_vr_za, r_vr_zb;

    rkst_ram #(.WIDTH($bits(t_node)), .DEPTH(NODE_POOL)) u_node_ram (
        .i_clk     (i_clk),
        .i_we      (nd_we),
        .i_waddr   (nd_wa),
        .i_wdata   (nd_wd),
        .i_raddr_a (nd_ra),
        .o_rdata_a (nd_raw_a),
        .i_raddr_b (nd_rb),
        .o_rdata_b (nd_raw_b)
    );

    rkst_ram #(.WIDTH(PW), .DEPTH(VD)) u_root_ram (
        .i_clk     (i_clk),
        .i_we      (vr_we),
        .i_waddr   (vr_wa),
        .i_wdata   (vr_wd),
        .i_raddr_a (vr_ra),
        .o_rdata_a (vr_raw_a),
        .i_raddr_b (vr_rb),
        .o_rdata_b (vr_raw_b)
    );

    // entry 0 of both stores is never written; it reads as the empty node / version
    assign nd_a = r_nd_za ? '0 : nd_raw_a;
    assign nd_b = r_nd_zb ? '0 : nd_raw_b;
    assign vr_a = r_vr_za ? '0 : vr_raw_a;
    assign vr_b = r_vr_zb ? '0 : vr_raw_b;

    assign uw         = uc_rom(r_step);
    assign o_in_ready = (r_step == STEP_IDLE);
    assign in_accept  = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    assign val    = VALUE_BITS'(r_item.value);
    assign sh     = r_lvl - LW'(1);
    assign val_sh = val >> sh;
    assign app_bit = val_sh[0];

    assign full = (r_total == CW'(MAX_ELEMENTS)) ||
                  (r_next_free > FW'(NODE_POOL - VALUE_BITS - 1));

    assign range_len = KW'(r_item.right_index) - KW'(r_item.left_index) + KW'(1);
    assign invalid = (r_item.left_index == '0) ||
                     (KW'(r_item.right_index) > KW'(r_total)) ||
                     (r_item.left_index > r_item.right_index) ||
                     (r_item.rank == '0) ||
                     (KW'(r_item.rank) > range_len);

    assign diff       = nd_b.lc - nd_a.lc;
    assign x          = KW'(diff);
    assign take_right = (r_k >= x);

    // datapath
    always_comb begin
        n_total     = r_total;
        n_next_free = r_next_free;
        n_res       = r_res;
        n_k         = r_k;
        n_lvl       = r_lvl;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        nd_we       = 1'b0;
        nd_wa       = PW'(r_next_free);
        nd_wd       = '0;
        nd_ra       = '0;
        nd_rb       = '0;
        vr_we       = 1'b0;
        vr_wa       = r_total + CW'(1);
        vr_wd       = PW'(r_next_free);
        vr_ra       = r_total;
        vr_rb       = '0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (uw.dp)
            DP_NONE: begin
            end
            DP_APP_CHECK: begin
                vr_ra = r_total;
                vr_we = !full;
            end
            DP_APP_ROOT: begin
                nd_ra = vr_a;
                n_lvl = LW'(VALUE_BITS);
            end
            DP_APP_LEVEL: begin
                // copy the old node; path child is the next node taken
                nd_we = 1'b1;
                if (app_bit) begin
                    nd_wd = '{lc: nd_a.lc, left: nd_a.left, right: PW'(r_next_free + FW'(1))};
                    nd_ra = nd_a.right;
                end else begin
                    nd_wd = '{lc: nd_a.lc + CW'(1), left: PW'(r_next_free + FW'(1)),
                              right: nd_a.right};
                    nd_ra = nd_a.left;
                end
                n_next_free = r_next_free + FW'(1);
                n_lvl       = r_lvl - LW'(1);
            end
            DP_APP_LEAF: begin
                nd_we       = 1'b1;
                nd_wd       = '0;
                n_next_free = r_next_free + FW'(1);
                n_total     = r_total + CW'(1);
            end
            DP_Q_CHECK: begin
                vr_ra = CW'(r_item.left_index - INDEX_W'(1));
                vr_rb = CW'(r_item.right_index);
                n_k   = KW'(r_item.rank) - KW'(1);
                n_res = '0;
            end
            DP_Q_ROOT: begin
                nd_ra = vr_a;
                nd_rb = vr_b;
                n_lvl = LW'(VALUE_BITS);
            end
            DP_Q_LEVEL: begin
                if (take_right) begin
                    n_k   = r_k - x;
                    n_res = r_res | (VALUE_BITS'(1) << sh);
                    nd_ra = nd_a.right;
                    nd_rb = nd_b.right;
                end else begin
                    nd_ra = nd_a.left;
                    nd_rb = nd_b.left;
                end
                n_lvl = r_lvl - LW'(1);
            end
            DP_OUT: begin
                if (out_free) begin
                    n_out_valid     = 1'b1;
                    n_out.status    = uw.st;
                    n_out.kth_value = (uw.st == ST_QUERY) ? VALUE_W'(r_res) : '0;
                end
            end
            default: begin
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_step = r_step + 4'd1;
        case (uw.jc)
            JC_NEXT:       n_step = r_step + 4'd1;
            JC_GOTO:       n_step = uw.tgt;
            JC_DISPATCH: begin
                if (!in_accept) begin
                    n_step = r_step;
                end else if (i_in_data.operation) begin
                    n_step = uw.alt;
                end else begin
                    n_step = uw.tgt;
                end
            end
            JC_IF_FULL:    n_step = full ? uw.tgt : r_step + 4'd1;
            JC_IF_INVALID: n_step = invalid ? uw.tgt : r_step + 4'd1;
            JC_LOOP:       n_step = (r_lvl != LW'(1)) ? uw.tgt : r_step + 4'd1;
            JC_OUT:        n_step = out_free ? uw.tgt : r_step;
            default:       n_step = STEP_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= STEP_IDLE;
            r_total     <= '0;
            r_next_free <= FW'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_step      <= n_step;
            r_total     <= n_total;
            r_next_free <= n_next_free;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item <= i_in_data;
        end
        r_res   <= n_res;
        r_k     <= n_k;
        r_lvl   <= n_lvl;
        r_out   <= n_out;
        r_nd_za <= (nd_ra == '0);
        r_nd_zb <= (nd_rb == '0);
        r_vr_za <= (vr_ra == '0);
        r_vr_zb <= (vr_rb == '0);
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

[hw/rtl/rkst_checker.sv]
// Port-level checks of the range k-th smallest block, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

module rkst_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                o_in_ready,
    input wire logic                o_out_valid,
    input wire logic                i_out_ready,
    input wire rkst_pkg::t_out_item o_out_data
);

    import rkst_pkg::*;

    // a result word stays offered until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result word dropped before it was taken");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("stalled result word changed");

    // only a completed query carries a value
    a_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != ST_QUERY |-> o_out_data.kth_value == '0)
        else $error("non-query result with non-zero value");

    // an accepted word leaves the sequencer busy in the cycle after the accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken again straight after an accept");

endmodule

bind range_kth_smallest_persistent_tree rkst_checker u_rkst_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire
